// ===== src/pn_pkg.sv =====
// shared types and constants for the three-octave gradient noise pipeline
// no dependencies
package pn_pkg;

  localparam int GRID_BITS   = 7;
  localparam int BANK_ABITS  = 2 * (GRID_BITS - 1);
  localparam int COORD_BITS  = 10;
  localparam int FRAC_BITS   = 16;
  localparam int DOT_BITS    = 20;
  localparam int W_BITS      = 17;
  localparam int P_BITS      = 24;
  localparam int T_BITS      = 20;
  localparam int NUM_BANKS   = 4;

  localparam logic [17:0] THREE_ONE = 18'd196608;
  localparam logic [T_BITS-1:0] T_SAT = 20'd1792;
  localparam logic [13:0] RECIP7 = 14'd9363;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_EVAL  = 1'b1
  } func_t;

  typedef struct packed {
    logic                 we;
    logic [GRID_BITS-1:0] col;
    logic [GRID_BITS-1:0] row;
    logic [31:0]          data;
  } wr_req_t;

  // floor((dx*gc + dy*gs) / 2^14)
  function automatic logic signed [DOT_BITS-1:0] corner_dot(
    input logic signed [16:0] dx,
    input logic signed [16:0] dy,
    input logic [31:0] e
  );
    logic signed [32:0] pa;
    logic signed [32:0] pb;
    logic signed [33:0] sum;
    pa = dx * $signed(e[15:0]);
    pb = dy * $signed(e[31:16]);
    sum = {pa[32], pa} + {pb[32], pb};
    return sum[33:14];
  endfunction

endpackage

// ===== src/pn_bank.sv =====
// one bank of the gradient table: one write port, one registered read port
// depends on pn_pkg
module pn_bank (
  input  logic                          clk,
  input  logic                          we,
  input  logic [pn_pkg::BANK_ABITS-1:0] waddr,
  input  logic [31:0]                   wdata,
  input  logic                          re,
  input  logic [pn_pkg::BANK_ABITS-1:0] raddr,
  output logic [31:0]                   rdata_r
);
  import pn_pkg::*;

  logic [31:0] mem [2**BANK_ABITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== src/pn_octave.sv =====
// one noise octave: banked table copy, corner dots, smoothstep weights, lerps
// depends on pn_pkg and pn_bank
module pn_octave #(
  parameter int CELL_LOG2 = 5
) (
  input  logic                           clk,
  input  logic                           en,
  input  pn_pkg::wr_req_t                wr,
  input  logic [pn_pkg::COORD_BITS-1:0]  px,
  input  logic [pn_pkg::COORD_BITS-1:0]  py,
  output logic signed [pn_pkg::P_BITS-1:0] p_r
);
  import pn_pkg::*;

  logic [GRID_BITS-1:0]  x0, y0, x1, y1;
  logic [FRAC_BITS-1:0]  fx, fy;
  logic [31:0]           fxx, fyy;
  logic [31:0]           rd [NUM_BANKS];

  logic                  xpar_r, ypar_r;
  logic [FRAC_BITS-1:0]  fx_r, fy_r, fx2_r, fy2_r;

  logic [31:0]           c00, c10, c01, c11;
  logic signed [16:0]    dxl, dxh, dyl, dyh;
  logic [17:0]           kx, ky;
  logic [33:0]           wxp, wyp;
  logic signed [DOT_BITS-1:0] n00_r, n10_r, n01_r, n11_r;
  logic [W_BITS-1:0]     wx_r, wy_r, wy2_r;

  logic signed [20:0]    dt, db;
  logic signed [38:0]    pt, pbm;
  logic signed [21:0]    top_r, bot_r;

  logic signed [22:0]    dv;
  logic signed [40:0]    pv;

  assign x0 = GRID_BITS'(px >> CELL_LOG2);
  assign y0 = GRID_BITS'(py >> CELL_LOG2);
  assign x1 = x0 + GRID_BITS'(1);
  assign y1 = y0 + GRID_BITS'(1);
  assign fx = FRAC_BITS'(FRAC_BITS'(px[CELL_LOG2-1:0]) << (FRAC_BITS - CELL_LOG2));
  assign fy = FRAC_BITS'(FRAC_BITS'(py[CELL_LOG2-1:0]) << (FRAC_BITS - CELL_LOG2));
  assign fxx = fx * fx;
  assign fyy = fy * fy;

  // bank index {x parity, y parity}; the four corners always hit four banks
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [GRID_BITS-1:0] xs, ys;
    assign xs = (x0[0] == b[1]) ? x0 : x1;
    assign ys = (y0[0] == b[0]) ? y0 : y1;
    pn_bank u_bank (
      .clk     (clk),
      .we      (wr.we && (wr.col[0] == b[1]) && (wr.row[0] == b[0])),
      .waddr   ({wr.col[GRID_BITS-1:1], wr.row[GRID_BITS-1:1]}),
      .wdata   (wr.data),
      .re      (en),
      .raddr   ({xs[GRID_BITS-1:1], ys[GRID_BITS-1:1]}),
      .rdata_r (rd[b])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xpar_r <= x0[0];
      ypar_r <= y0[0];
      fx_r   <= fx;
      fy_r   <= fy;
      fx2_r  <= fxx[31:16];
      fy2_r  <= fyy[31:16];
    end
  end

  // stage 1: corner dots and smoothstep weights
  assign c00 = rd[{xpar_r, ypar_r}];
  assign c10 = rd[{~xpar_r, ypar_r}];
  assign c01 = rd[{xpar_r, ~ypar_r}];
  assign c11 = rd[{~xpar_r, ~ypar_r}];
  assign dxl = $signed({1'b0, fx_r});
  assign dyl = $signed({1'b0, fy_r});
  assign dxh = dxl - 17'sd65536;
  assign dyh = dyl - 17'sd65536;
  assign kx  = THREE_ONE - {1'b0, fx_r, 1'b0};
  assign ky  = THREE_ONE - {1'b0, fy_r, 1'b0};
  assign wxp = fx2_r * kx;
  assign wyp = fy2_r * ky;

  always_ff @(posedge clk) begin
    if (en) begin
      n00_r <= corner_dot(dxl, dyl, c00);
      n10_r <= corner_dot(dxh, dyl, c10);
      n01_r <= corner_dot(dxl, dyh, c01);
      n11_r <= corner_dot(dxh, dyh, c11);
      wx_r  <= wxp[32:16];
      wy_r  <= wyp[32:16];
    end
  end

  // stage 2: blend along x
  assign dt  = 21'(n10_r) - 21'(n00_r);
  assign db  = 21'(n11_r) - 21'(n01_r);
  assign pt  = dt * $signed({1'b0, wx_r});
  assign pbm = db * $signed({1'b0, wx_r});

  always_ff @(posedge clk) begin
    if (en) begin
      top_r <= 22'(n00_r) + 22'(pt >>> 16);
      bot_r <= 22'(n01_r) + 22'(pbm >>> 16);
      wy2_r <= wy_r;
    end
  end

  // stage 3: blend along y plus one half
  assign dv = 23'(bot_r) - 23'(top_r);
  assign pv = dv * $signed({1'b0, wy2_r});

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= P_BITS'(top_r) + P_BITS'(pv >>> 16) + 24'sd32768;
    end
  end

endmodule

// ===== src/perlin_noise_3_octave_pixel.sv =====
// top level of the three-octave gradient noise pixel generator
// depends on pn_pkg and pn_octave
//
// Accepts one item per clock while the output is not stalled. A write item (tuser 0)
// stores a gradient into three copies of the 128x128 table, one per octave, each
// split into four banks; it gives no result. An evaluate item (tuser 1) gives one
// grey level through a seven-register pipeline (input, table read, corner dots,
// x blend, y blend, octave sum with scaling, divide and saturation). The
// whole pipeline advances whenever the output register is empty or being taken.
// Table entries come up undefined after reset and must be written before an
// evaluate reads them.
module perlin_noise_3_octave_pixel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // cell_col, cell_row, grad_cos, grad_sin, pixel_col, pixel_row
  input  logic        in_tuser,  // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata  // pixel_value
);
  import pn_pkg::*;

  logic                   en;
  logic                   v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  func_t                  func_r;
  logic [65:0]            dat_r;
  wr_req_t                wr;
  logic [COORD_BITS-1:0]  px, py;
  logic signed [P_BITS-1:0] p1, p2, p3;
  logic signed [26:0]     s;
  logic signed [35:0]     m;
  logic signed [T_BITS-1:0] t_r;
  logic                   pos_r;
  logic [24:0]            q;
  logic [7:0]             pix_nxt, pix_r;

  assign en        = !v6_r || out_tready;
  assign in_tready = en && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r && (func_r == FUNC_EVAL);
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func_r <= func_t'(in_tuser);
      dat_r  <= in_tdata[65:0];
    end
  end

  assign wr.we   = en && v0_r && (func_r == FUNC_WRITE);
  assign wr.col  = dat_r[6:0];
  assign wr.row  = dat_r[13:7];
  assign wr.data = {dat_r[45:30], dat_r[29:14]};
  assign px      = dat_r[55:46];
  assign py      = dat_r[65:56];

  pn_octave #(.CELL_LOG2(5)) u_oct1 (
    .clk(clk), .en(en), .wr(wr), .px(px), .py(py), .p_r(p1));
  pn_octave #(.CELL_LOG2(4)) u_oct2 (
    .clk(clk), .en(en), .wr(wr), .px(px), .py(py), .p_r(p2));
  pn_octave #(.CELL_LOG2(3)) u_oct3 (
    .clk(clk), .en(en), .wr(wr), .px(px), .py(py), .p_r(p3));

  // weighted sum and scale by 255 / 2^16
  assign s = (27'(p1) <<< 2) + (27'(p2) <<< 1) + 27'(p3);
  assign m = (36'(s) <<< 8) - 36'(s);

  always_ff @(posedge clk) begin
    if (en) begin
      t_r   <= m[35:16];
      pos_r <= (s > 27'sd0);
    end
  end

  // divide by 7 with a reciprocal, saturate
  assign q = t_r[10:0] * RECIP7;

  always_comb begin
    if (!pos_r) begin
      pix_nxt = 8'd0;
    end else if (t_r >= $signed(T_SAT)) begin
      pix_nxt = 8'd255;
    end else begin
      pix_nxt = q[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_tvalid = v6_r;
  assign out_tdata  = pix_r;

endmodule

// ===== src/pn_check.sv =====
// port-level checks for the noise pixel generator, bound to the top level
// depends on perlin_noise_3_octave_pixel
module pn_check (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("input stalled with empty output");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready) else $error("input taken during stall");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("output item dropped");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("output item changed");

endmodule

bind perlin_noise_3_octave_pixel pn_check u_pn_check (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata));
